>>> design/rlt_pkg.sv
package rlt_pkg;

    localparam int STACK_DEPTH   = 256;
    localparam int SYMBOL_BITS   = 8;
    localparam int COUNT_BITS    = 32;
    localparam int POSITION_BITS = 48;
    localparam int DEPTH_BITS    = $clog2(STACK_DEPTH + 1);
    localparam int SUM_BITS      = COUNT_BITS + $clog2(2 * STACK_DEPTH);
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 8;

    localparam logic [1:0] FN_SINGLE  = 2'd0;
    localparam logic [1:0] FN_CHAIN   = 2'd1;
    localparam logic [1:0] FN_COUNT   = 2'd2;
    localparam logic [1:0] FN_RESTART = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_SAT     = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_BLANK = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START = 1'd1;

    typedef struct packed {
        logic [SYMBOL_BITS-1:0] sym;
        logic [COUNT_BITS-1:0]  cnt;
        logic                   inf;
    } t_run;

    typedef enum logic [1:0] {
        SH_KEEP,
        SH_DOWN,
        SH_UP
    } t_shift;

    // per-stack command: shift mode, new top entry, entry pushed below it
    typedef struct packed {
        t_shift shift;
        t_run   top;
        t_run   sec;
    } t_stack_ctl;

endpackage

>>> design/rlt_in_if.sv
interface rlt_in_if;
    import rlt_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [1:0]             func;
    logic [SYMBOL_BITS-1:0] write_symbol;
    logic                   move_direction;
    logic [COUNT_BITS-1:0]  base_value;

    modport source (output valid, func, write_symbol, move_direction, base_value,
                    input ready);
    modport sink   (input valid, func, write_symbol, move_direction, base_value,
                    output ready);
endinterface

>>> design/rlt_out_if.sv
interface rlt_out_if;
    import rlt_pkg::*;
    logic                            valid;
    logic                            ready;
    logic [SYMBOL_BITS-1:0]          top_symbol;
    logic [COUNT_BITS-1:0]           top_count;
    logic                            top_infinite;
    logic [COUNT_BITS-1:0]           moved_count;
    logic                            moved_infinite;
    logic [COUNT_BITS-1:0]           cell_total;
    logic signed [POSITION_BITS-1:0] head_position;
    logic                            head_direction;
    logic [1:0]                      status;

    modport source (output valid, top_symbol, top_count, top_infinite, moved_count,
                    moved_infinite, cell_total, head_position, head_direction,
                    status, input ready);
    modport sink   (input valid, top_symbol, top_count, top_infinite, moved_count,
                    moved_infinite, cell_total, head_position, head_direction,
                    status, output ready);
endinterface

>>> design/run_length_two_stack_tape.sv
// Channel  | Dir | Payload                                           | Handshake
// i_in     | in  | func, write_symbol, move_direction, base_value    | valid/ready
// o_out    | out | top/moved/total fields, position, direction, status | valid/ready
// i_cfg_*  | in  | register index, data                              | write enable
//
// One item per cycle while the output drains: every operation touches only the two
// stack tops and the running finite-cell sum, so the result is registered in the
// cycle after acceptance. Counting reads the running sum instead of walking the stacks.
// Synchronous active-low reset rebuilds the blank tape (blank 0, facing left).
// Input is taken whenever the output register is empty or being drained.
module run_length_two_stack_tape
    import rlt_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    rlt_in_if.sink                   i_in,
    rlt_out_if.source                o_out,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    // config
    logic [SYMBOL_BITS-1:0] r_blank;
    logic                   r_start_dir;

    // tape state
    logic [DEPTH_BITS-1:0]    r_depth [2];
    logic [DEPTH_BITS-1:0]    n_depth [2];
    logic                     r_facing,  n_facing;
    logic [POSITION_BITS-1:0] r_disp,    n_disp;
    logic [SUM_BITS-1:0]      r_sum,     n_sum;   // sum of all finite run counts

    t_stack_ctl w_ctl [2];
    t_run       w_top [2];
    t_run       w_sec [2];

    // output register
    logic                   r_out_valid;
    t_run                   r_res_top,   n_res_top;
    logic [COUNT_BITS-1:0]  r_moved,     n_moved;
    logic                   r_moved_inf, n_moved_inf;
    logic [COUNT_BITS-1:0]  r_total,     n_total;
    logic [1:0]             r_status,    n_status;

    logic w_accept;
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    for (genvar s = 0; s < 2; s++) begin : g_stack
        rlt_stack u_stack (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[s]),
            .o_top   (w_top[s]),
            .o_sec   (w_sec[s])
        );
    end

    // move datapath
    logic                  w_f, w_g, w_chain, w_pop, w_merge, w_carry, w_full, w_sat;
    t_run                  w_t, w_e, w_base, w_merged, w_new, w_blank_run;
    logic [COUNT_BITS-1:0] w_n, w_dec, w_sum_cnt;
    logic [DEPTH_BITS-1:0] w_base_depth;
    logic [SUM_BITS-1:0]   w_removed, w_added;
    logic [SUM_BITS:0]     w_count_sum;

    always_comb begin
        w_f     = r_facing;
        w_t     = w_top[w_f];
        w_chain = (i_in.func == FN_CHAIN);
        w_g     = w_chain ? ~w_f : ~i_in.move_direction;
        w_n     = w_chain ? w_t.cnt : COUNT_BITS'(1);
        w_dec   = w_t.cnt - COUNT_BITS'(1);
        // single move leaves the run when its last cell goes
        w_pop   = w_chain || (!w_t.inf && (w_dec == '0));
        if (w_pop) begin
            w_e = w_sec[w_f];
        end else if (w_t.inf) begin
            w_e = w_t;
        end else begin
            w_e = '{sym: w_t.sym, cnt: w_dec, inf: 1'b0};
        end
        w_base       = (w_g == w_f) ? w_e : w_top[w_g];
        w_base_depth = (w_g == w_f) ? (r_depth[w_f] - DEPTH_BITS'(w_pop)) : r_depth[w_g];
        w_merge      = (w_base.sym == i_in.write_symbol);
        {w_carry, w_sum_cnt} = {1'b0, w_base.cnt} + {1'b0, w_n};
        w_sat        = w_merge && !w_base.inf && w_carry;
        if (w_base.inf) begin
            w_merged = w_base;
        end else begin
            w_merged = '{sym: w_base.sym, cnt: w_carry ? CNT_MAX : w_sum_cnt, inf: 1'b0};
        end
        w_new     = w_merge ? w_merged : '{sym: i_in.write_symbol, cnt: w_n, inf: 1'b0};
        w_full    = !w_merge && (w_base_depth >= DEPTH_BITS'(STACK_DEPTH));
        w_removed = w_chain ? SUM_BITS'(w_n) : SUM_BITS'(!w_t.inf);
        if (!w_merge) begin
            w_added = SUM_BITS'(w_n);
        end else if (w_base.inf) begin
            w_added = '0;
        end else begin
            w_added = SUM_BITS'(w_merged.cnt - w_base.cnt);
        end
        w_count_sum = {1'b0, SUM_BITS'(i_in.base_value)} + {1'b0, r_sum};
        w_blank_run = '{sym: r_blank, cnt: '0, inf: 1'b1};
    end

    always_comb begin
        for (int s = 0; s < 2; s++) begin
            w_ctl[s] = '{shift: SH_KEEP, top: w_top[s], sec: w_top[s]};
            n_depth[s] = r_depth[s];
        end
        n_facing    = r_facing;
        n_disp      = r_disp;
        n_sum       = r_sum;
        n_moved     = '0;
        n_moved_inf = 1'b0;
        n_total     = '0;
        n_status    = ST_OK;

        if (w_accept) begin
            unique case (i_in.func)
                FN_SINGLE, FN_CHAIN: begin
                    if (w_chain && w_t.inf) begin
                        n_moved_inf = 1'b1;
                    end else if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        if (w_sat) begin
                            n_status = ST_SAT;
                        end
                        if (w_g == w_f) begin
                            // take and write on the same side: net shift of at most one
                            w_ctl[w_f].top = w_new;
                            w_ctl[w_f].sec = w_e;
                            if (w_merge) begin
                                w_ctl[w_f].shift = w_pop ? SH_UP : SH_KEEP;
                            end else begin
                                w_ctl[w_f].shift = w_pop ? SH_KEEP : SH_DOWN;
                            end
                            n_depth[w_f] = w_base_depth + DEPTH_BITS'(!w_merge);
                        end else begin
                            w_ctl[w_f] = '{shift: w_pop ? SH_UP : SH_KEEP,
                                           top: w_e, sec: w_e};
                            n_depth[w_f] = r_depth[w_f] - DEPTH_BITS'(w_pop);
                            w_ctl[w_g] = '{shift: w_merge ? SH_KEEP : SH_DOWN,
                                           top: w_new, sec: w_top[w_g]};
                            n_depth[w_g] = r_depth[w_g] + DEPTH_BITS'(!w_merge);
                        end
                        n_facing = w_chain ? w_f : i_in.move_direction;
                        if (n_facing) begin
                            n_disp = r_disp + POSITION_BITS'(w_n);
                        end else begin
                            n_disp = r_disp - POSITION_BITS'(w_n);
                        end
                        n_sum   = r_sum - w_removed + w_added;
                        n_moved = w_chain ? w_n : '0;
                    end
                end
                FN_COUNT: begin
                    if (w_count_sum > (SUM_BITS + 1)'(CNT_MAX)) begin
                        n_total  = CNT_MAX;
                        n_status = ST_SAT;
                    end else begin
                        n_total = w_count_sum[COUNT_BITS-1:0];
                    end
                end
                default: begin
                    for (int s = 0; s < 2; s++) begin
                        w_ctl[s]   = '{shift: SH_KEEP, top: w_blank_run, sec: w_blank_run};
                        n_depth[s] = DEPTH_BITS'(1);
                    end
                    n_facing = r_start_dir;
                    n_disp   = '0;
                    n_sum    = '0;
                end
            endcase
        end
        // stack top register always loads ctl.top
        n_res_top = w_ctl[n_facing].top;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank     <= '0;
            r_start_dir <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BLANK: r_blank     <= i_cfg_data[SYMBOL_BITS-1:0];
                CFG_START: r_start_dir <= i_cfg_data[0];
                default:   r_blank     <= r_blank;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth[0]  <= DEPTH_BITS'(1);
            r_depth[1]  <= DEPTH_BITS'(1);
            r_facing    <= 1'b0;
            r_disp      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_depth[0] <= n_depth[0];
            r_depth[1] <= n_depth[1];
            r_facing   <= n_facing;
            r_disp     <= n_disp;
            r_sum      <= n_sum;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res_top   <= n_res_top;
            r_moved     <= n_moved;
            r_moved_inf <= n_moved_inf;
            r_total     <= n_total;
            r_status    <= n_status;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.top_symbol     = r_res_top.sym;
    assign o_out.top_count      = r_res_top.inf ? '0 : r_res_top.cnt;
    assign o_out.top_infinite   = r_res_top.inf;
    assign o_out.moved_count    = r_moved;
    assign o_out.moved_infinite = r_moved_inf;
    assign o_out.cell_total     = r_total;
    assign o_out.head_position  = r_disp;
    assign o_out.head_direction = r_facing;
    assign o_out.status         = r_status;

    // infinite blank run never leaves the bottom
    a_depth_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth[0] != '0) else $error("left stack lost its bottom run");
    a_depth_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth[1] != '0) else $error("right stack lost its bottom run");
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.func == FN_RESTART) |=> (o_out.top_infinite && r_disp == '0))
        else $error("restart did not rebuild blank tape");
    a_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && n_status == ST_FULL) |=> ($stable(r_disp) && r_moved == '0))
        else $error("refused push changed state");

endmodule

>>> design/rlt_cell.sv
module rlt_cell
    import rlt_pkg::*;
(
    input  logic   i_clk,
    input  t_shift i_shift,
    input  t_run   i_prev,
    input  t_run   i_next,
    output t_run   o_run
);

    t_run r_run;

    always_ff @(posedge i_clk) begin
        unique case (i_shift)
            SH_DOWN: begin
                r_run <= i_prev;
            end
            SH_UP: begin
                r_run <= i_next;
            end
            default: begin
                r_run <= r_run;
            end
        endcase
    end

    assign o_run = r_run;

endmodule

>>> design/rlt_stack.sv
module rlt_stack
    import rlt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_stack_ctl i_ctl,
    output t_run       o_top,
    output t_run       o_sec
);

    t_run r_top;
    t_run w_cell [STACK_DEPTH];

    // top entry always loads the computed value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= '{sym: '0, cnt: '0, inf: 1'b1};
        end else begin
            r_top <= i_ctl.top;
        end
    end

    assign w_cell[0] = r_top;

    for (genvar k = 1; k < STACK_DEPTH; k++) begin : g_cell
        t_run w_prev;
        t_run w_next;
        assign w_prev = (k == 1) ? i_ctl.sec : w_cell[k-1];
        assign w_next = (k == STACK_DEPTH - 1) ? w_cell[k] : w_cell[(k + 1) % STACK_DEPTH];
        rlt_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (i_ctl.shift),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_run   (w_cell[k])
        );
    end

    assign o_top = r_top;
    assign o_sec = w_cell[1];

endmodule

>>> verif/run_length_two_stack_tape_test.sv
module run_length_two_stack_tape_test;
    import rlt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One input item: operation plus its operands.
    typedef struct packed {
        logic [1:0]             func;
        logic [SYMBOL_BITS-1:0] wsym;
        logic                   mdir;
        logic [COUNT_BITS-1:0]  base;
    } tape_op_t;

    // One result item as seen on the output channel.
    typedef struct packed {
        logic [SYMBOL_BITS-1:0]          top_symbol;
        logic [COUNT_BITS-1:0]           top_count;
        logic                            top_infinite;
        logic [COUNT_BITS-1:0]           moved_count;
        logic                            moved_infinite;
        logic [COUNT_BITS-1:0]           cell_total;
        logic [POSITION_BITS-1:0]        head_position;
        logic                            head_direction;
        logic [1:0]                      status;
    } tape_view_t;

    // Directed row: optional typed-in total and status for the obvious cases.
    typedef struct packed {
        tape_op_t               op;
        logic                   typed;
        logic [COUNT_BITS-1:0]  exp_total;
        logic [1:0]             exp_status;
    } dir_row_t;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    rlt_in_if  in_ch();
    rlt_out_if out_ch();

    run_length_two_stack_tape dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // ---------------------------------------------------------------
    // Tape mirror: two run stacks, head facing, displacement, registers
    // ---------------------------------------------------------------
    t_run                     tape_runs [2][STACK_DEPTH];
    int unsigned              side_depth[2];
    logic                     head_facing;
    logic [POSITION_BITS-1:0] head_disp;
    logic [SYMBOL_BITS-1:0]   blank_reg;
    logic                     start_dir_reg;

    tape_view_t pending_views[$];
    int         err_count;
    int         send_idle_pct;
    int         recv_idle_pct;
    bit         recv_hold;

    function automatic void rebuild_tape();
        for (int s = 0; s < 2; s++) begin
            for (int i = 0; i < STACK_DEPTH; i++)
                tape_runs[s][i] = '0;
            tape_runs[s][0].sym = blank_reg;
            tape_runs[s][0].inf = 1'b1;
            side_depth[s] = 1;
        end
        head_facing = start_dir_reg;
        head_disp   = '0;
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_sum(logic [COUNT_BITS-1:0] a,
                                                      logic [COUNT_BITS-1:0] b,
                                                      inout logic [1:0] st);
        logic [COUNT_BITS:0] wide;
        wide = {1'b0, a} + {1'b0, b};
        if (wide[COUNT_BITS]) begin
            st = ST_SAT;
            return CNT_MAX;
        end
        return wide[COUNT_BITS-1:0];
    endfunction

    // Lay n cells of sym on side s, merging with an equal top run.
    function automatic bit lay_cells(int s, logic [SYMBOL_BITS-1:0] sym,
                                     logic [COUNT_BITS-1:0] n, inout logic [1:0] st);
        int unsigned d;
        d = side_depth[s];
        if (tape_runs[s][d-1].sym == sym) begin
            if (!tape_runs[s][d-1].inf)
                tape_runs[s][d-1].cnt = sat_sum(tape_runs[s][d-1].cnt, n, st);
            return 1'b1;
        end
        if (d >= STACK_DEPTH)
            return 1'b0;
        tape_runs[s][d].sym = sym;
        tape_runs[s][d].cnt = n;
        tape_runs[s][d].inf = 1'b0;
        side_depth[s] = d + 1;
        return 1'b1;
    endfunction

    function automatic tape_view_t step_tape(tape_op_t op);
        tape_view_t  v;
        int          f;
        int          tgt;
        int unsigned saved_depth;
        t_run        saved_top;
        logic [COUNT_BITS-1:0] n;
        logic        d;
        t_run        t;
        v = '0;
        v.status = ST_OK;
        if (op.func == FN_SINGLE || op.func == FN_CHAIN) begin
            f = head_facing;
            saved_depth = side_depth[f];
            saved_top = tape_runs[f][saved_depth-1];
            tgt = (op.func == FN_SINGLE) ? (1 - op.mdir) : (1 - f);
            n = 1;
            if (op.func == FN_CHAIN && saved_top.inf) begin
                v.moved_infinite = 1'b1;
            end else begin
                if (op.func == FN_CHAIN) begin
                    n = saved_top.cnt;
                    side_depth[f]--;
                end else if (!saved_top.inf) begin
                    tape_runs[f][saved_depth-1].cnt = saved_top.cnt - 1'b1;
                    if (tape_runs[f][saved_depth-1].cnt == 0 && saved_depth > 1)
                        side_depth[f]--;
                end
                if (!lay_cells(tgt, op.wsym, n, v.status)) begin
                    // refused push leaves the tape exactly as it was
                    side_depth[f] = saved_depth;
                    tape_runs[f][saved_depth-1] = saved_top;
                    v.status = ST_FULL;
                end else begin
                    d = (op.func == FN_SINGLE) ? op.mdir : head_facing;
                    head_facing = d;
                    if (d)
                        head_disp = head_disp + POSITION_BITS'(n);
                    else
                        head_disp = head_disp - POSITION_BITS'(n);
                    if (op.func == FN_CHAIN)
                        v.moved_count = n;
                end
            end
        end else if (op.func == FN_COUNT) begin
            v.cell_total = op.base;
            for (int s = 0; s < 2; s++)
                for (int i = 0; i < side_depth[s]; i++)
                    if (!tape_runs[s][i].inf)
                        v.cell_total = sat_sum(v.cell_total, tape_runs[s][i].cnt, v.status);
        end else begin
            rebuild_tape();
        end
        t = tape_runs[head_facing][side_depth[head_facing]-1];
        v.top_symbol     = t.sym;
        v.top_count      = t.inf ? '0 : t.cnt;
        v.top_infinite   = t.inf;
        v.head_position  = head_disp;
        v.head_direction = head_facing;
        return v;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        err_count++;
        if (err_count <= 40)
            $display("%0t mismatch %s: got %0h expected %0h", $realtime, field, got, want);
    endtask

    // ---------------------------------------------------------------
    // Clock, limit
    // ---------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3ms;
        $display("run_length_two_stack_tape_test: FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // Checker: results compared first, then the newly accepted item is
    // predicted. Both use pre-edge values, so event order does not matter.
    // ---------------------------------------------------------------
    bit                    typed_valid;
    logic [COUNT_BITS-1:0] typed_total;
    logic [1:0]            typed_status;

    always @(posedge i_clk) begin
        tape_view_t got, want;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.top_symbol, out_ch.top_count, out_ch.top_infinite,
                        out_ch.moved_count, out_ch.moved_infinite, out_ch.cell_total,
                        out_ch.head_position, out_ch.head_direction, out_ch.status};
                if (pending_views.size() == 0) begin
                    report_mismatch("unexpected item", 64'(got.status), 64'd0);
                end else begin
                    want = pending_views.pop_front();
                    if (got.top_symbol != want.top_symbol)
                        report_mismatch("top_symbol", 64'(got.top_symbol), 64'(want.top_symbol));
                    if (got.top_count != want.top_count)
                        report_mismatch("top_count", 64'(got.top_count), 64'(want.top_count));
                    if (got.top_infinite != want.top_infinite)
                        report_mismatch("top_infinite", 64'(got.top_infinite),
                                        64'(want.top_infinite));
                    if (got.moved_count != want.moved_count)
                        report_mismatch("moved_count", 64'(got.moved_count),
                                        64'(want.moved_count));
                    if (got.moved_infinite != want.moved_infinite)
                        report_mismatch("moved_infinite", 64'(got.moved_infinite),
                                        64'(want.moved_infinite));
                    if (got.cell_total != want.cell_total)
                        report_mismatch("cell_total", 64'(got.cell_total), 64'(want.cell_total));
                    if (got.head_position !== want.head_position)
                        report_mismatch("head_position", 64'(got.head_position),
                                        64'(want.head_position));
                    if (got.head_direction != want.head_direction)
                        report_mismatch("head_direction", 64'(got.head_direction),
                                        64'(want.head_direction));
                    if (got.status != want.status)
                        report_mismatch("status", 64'(got.status), 64'(want.status));
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                want = step_tape('{in_ch.func, in_ch.write_symbol, in_ch.move_direction,
                                   in_ch.base_value});
                // directed rows with values read straight off the spec
                if (typed_valid) begin
                    want.cell_total = typed_total;
                    want.status     = typed_status;
                end
                pending_views = {pending_views, want};
            end
        end
    end

    // Receiver: random back-pressure plus the long hold-off.
    always @(negedge i_clk) begin
        out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // ---------------------------------------------------------------
    // Driving helpers, all entered and left just after a falling edge
    // ---------------------------------------------------------------
    task automatic send_item(tape_op_t op, bit typed, logic [COUNT_BITS-1:0] tot,
                             logic [1:0] st);
        if ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.func           <= op.func;
        in_ch.write_symbol   <= op.wsym;
        in_ch.move_direction <= op.mdir;
        in_ch.base_value     <= op.base;
        typed_valid          <= typed;
        typed_total          <= tot;
        typed_status         <= st;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_op(tape_op_t op);
        send_item(op, 1'b0, '0, ST_OK);
    endtask

    // Stop offering and let the block drain before touching registers.
    task automatic settle();
        in_ch.valid <= 1'b0;
        typed_valid <= 1'b0;
        while (pending_views.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == CFG_BLANK)
            blank_reg = data;
        else
            start_dir_reg = data[0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Symbols from a small pool so runs merge and chain moves carry real runs.
    function automatic logic [SYMBOL_BITS-1:0] pool_symbol();
        case ($urandom_range(5))
            0:       return blank_reg;
            1:       return '1;
            2:       return '0;
            default: return SYMBOL_BITS'($urandom_range(1, 3));
        endcase
    endfunction

    function automatic tape_op_t walk_op();
        tape_op_t op;
        op.func = ($urandom_range(3) == 0) ? FN_CHAIN : FN_SINGLE;
        op.wsym = pool_symbol();
        op.mdir = 1'($urandom_range(1));
        op.base = $urandom;
        return op;
    endfunction

    // One burst of random items: mostly well-formed walks, a stack fill,
    // counts near saturation, restarts, and plain noise.
    task automatic random_burst(inout int sent);
        tape_op_t op;
        int       len;
        logic     dir;
        case ($urandom_range(9))
            0: begin
                // fill the stack opposite dir with alternating runs until refused
                dir = 1'($urandom_range(1));
                for (int k = 0; k < STACK_DEPTH + 8; k++) begin
                    op.func = FN_SINGLE;
                    op.mdir = dir;
                    op.wsym = k[0] ? 8'hA5 : 8'h5A;
                    op.base = '0;
                    send_op(op);
                end
                op.func = ($urandom_range(1) == 0) ? FN_CHAIN : FN_SINGLE;
                op.mdir = dir;
                op.wsym = 8'h3C;
                send_op(op);
                op.func = FN_COUNT;
                op.base = CNT_MAX - COUNT_BITS'($urandom_range(400));
                send_op(op);
                sent += STACK_DEPTH + 10;
            end
            1: begin
                op = '0;
                op.func = FN_COUNT;
                op.base = ($urandom_range(1) == 0) ? $urandom :
                          CNT_MAX - COUNT_BITS'($urandom_range(300));
                send_op(op);
                sent++;
            end
            2: begin
                op = '0;
                op.func = FN_RESTART;
                op.base = $urandom;
                send_op(op);
                sent++;
            end
            3: begin
                op = '{2'($urandom_range(3)), SYMBOL_BITS'($urandom_range(255)),
                       1'($urandom_range(1)), $urandom};
                send_op(op);
                sent++;
            end
            default: begin
                len = $urandom_range(5, 30);
                for (int k = 0; k < len; k++)
                    send_op(walk_op());
                sent += len;
            end
        endcase
    endtask

    task automatic random_phase(int target);
        int sent;
        sent = 0;
        while (sent < target)
            random_burst(sent);
    endtask

    // Directed rows from the reset state (blank 0, facing left).
    dir_row_t dir_rows[] = '{
        '{'{FN_COUNT,   8'h00, 1'b0, 32'h0},        1'b1, 32'h0,        ST_OK},
        '{'{FN_COUNT,   8'h00, 1'b0, 32'hFFFFFFFF}, 1'b1, 32'hFFFFFFFF, ST_OK},
        '{'{FN_CHAIN,   8'h05, 1'b0, 32'h0},        1'b0, 32'h0,        ST_OK},
        '{'{FN_SINGLE,  8'h07, 1'b1, 32'h0},        1'b0, 32'h0,        ST_OK},
        '{'{FN_SINGLE,  8'h07, 1'b1, 32'h0},        1'b0, 32'h0,        ST_OK},
        // write of blank onto the infinite blank run just merges
        '{'{FN_SINGLE,  8'h00, 1'b0, 32'h0},        1'b0, 32'h0,        ST_OK},
        '{'{FN_COUNT,   8'h00, 1'b0, 32'hFFFFFFFF}, 1'b1, 32'hFFFFFFFF, ST_SAT},
        '{'{FN_COUNT,   8'h00, 1'b0, 32'hFFFFFFFD}, 1'b1, 32'hFFFFFFFF, ST_OK},
        '{'{FN_CHAIN,   8'h09, 1'b1, 32'h0},        1'b0, 32'h0,        ST_OK},
        // chain move facing the infinite run does nothing
        '{'{FN_CHAIN,   8'hFF, 1'b0, 32'h0},        1'b0, 32'h0,        ST_OK},
        '{'{FN_SINGLE,  8'hFF, 1'b0, 32'h0},        1'b0, 32'h0,        ST_OK},
        '{'{FN_SINGLE,  8'hFF, 1'b1, 32'h0},        1'b0, 32'h0,        ST_OK},
        '{'{FN_SINGLE,  8'h80, 1'b1, 32'h0},        1'b0, 32'h0,        ST_OK},
        '{'{FN_CHAIN,   8'h01, 1'b0, 32'h0},        1'b0, 32'h0,        ST_OK},
        '{'{FN_CHAIN,   8'h01, 1'b0, 32'h0},        1'b0, 32'h0,        ST_OK},
        '{'{FN_COUNT,   8'hFF, 1'b1, 32'h12345678}, 1'b0, 32'h0,        ST_OK},
        '{'{FN_RESTART, 8'hFF, 1'b1, 32'hFFFFFFFF}, 1'b1, 32'h0,        ST_OK},
        '{'{FN_COUNT,   8'h00, 1'b0, 32'h0},        1'b1, 32'h0,        ST_OK}
    };

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        in_ch.valid          = 1'b0;
        in_ch.func           = FN_SINGLE;
        in_ch.write_symbol   = '0;
        in_ch.move_direction = 1'b0;
        in_ch.base_value     = '0;
        out_ch.ready         = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = CFG_BLANK;
        i_cfg_data           = '0;
        i_rst_n              = 1'b0;
        typed_valid          = 1'b0;
        typed_total          = '0;
        typed_status         = ST_OK;
        recv_hold            = 1'b0;
        err_count            = 0;
        send_idle_pct        = 20;
        recv_idle_pct        = 82;
        blank_reg            = '0;
        start_dir_reg        = 1'b0;
        rebuild_tape();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[r])
            send_item(dir_rows[r].op, dir_rows[r].typed, dir_rows[r].exp_total,
                      dir_rows[r].exp_status);
        settle();

        // phase 1: sender light gaps, receiver mostly stalled; extreme blank
        write_reg(CFG_BLANK, 8'hFF);
        write_reg(CFG_START, 8'h01);
        random_phase(400);
        settle();

        // phase 2: roles swapped; blank back to zero, facing left
        send_idle_pct = 82;
        recv_idle_pct = 20;
        write_reg(CFG_BLANK, 8'h00);
        write_reg(CFG_START, 8'h00);
        random_phase(400);
        settle();

        // phase 3: full rate, with one long receiver hold-off so the
        // output side backs up and input ready drops
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_BLANK, CFG_DATA_BITS'($urandom_range(1, 254)));
        write_reg(CFG_START, CFG_DATA_BITS'($urandom_range(1)));
        fork
            begin
                recv_hold = 1'b1;
                repeat (80) @(posedge i_clk);
                recv_hold = 1'b0;
            end
        join_none
        random_phase(400);

        in_ch.valid <= 1'b0;
        typed_valid <= 1'b0;
        while (pending_views.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (err_count == 0)
            $display("run_length_two_stack_tape_test: PASS");
        else
            $display("run_length_two_stack_tape_test: FAIL");
        $finish;
    end

endmodule
